// ===== rtl/qri_pkg.sv =====
// Shared types, constants and decode functions for the quaternion rate integrator.
`default_nettype none
package qri_pkg;

  localparam int unsigned Q_W    = 32;  // quaternion and rate word width
  localparam int unsigned STEP_W = 29;  // step time register width
  localparam int unsigned MUL_W  = 33;  // signed multiplier operand width
  localparam int unsigned DER_W  = 40;  // derivative accumulator width

  localparam logic [STEP_W-1:0] STEP_RESET = 29'd21474836;

  // work phases of the sequencer
  localparam logic [1:0] PH_F = 2'd0;  // derivative from old rates
  localparam logic [1:0] PH_M = 2'd1;  // predictor step products
  localparam logic [1:0] PH_L = 2'd2;  // derivative from predictor and new rates
  localparam logic [1:0] PH_O = 2'd3;  // final step products

  localparam logic [3:0] TERM_LAST = 4'd11;
  localparam logic [3:0] STEP_LAST = 4'd7;

  typedef struct packed {
    logic [1:0] k;      // derivative component
    logic [1:0] p;      // quaternion component
    logic [1:0] w;      // rate axis
    logic       neg;
    logic       first;  // opens a fresh sum
  } term_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] phase;
    logic [3:0] idx;
  } acc_ctl_t;

  // terms of dq = 0.5 * q (x) (0, w), three per component
  function automatic term_t deriv_term(logic [3:0] idx);
    term_t t;
    t = '0;
    unique case (idx)
      4'd0:    t = '{k: 2'd0, p: 2'd1, w: 2'd0, neg: 1'b1, first: 1'b1};
      4'd1:    t = '{k: 2'd0, p: 2'd2, w: 2'd1, neg: 1'b1, first: 1'b0};
      4'd2:    t = '{k: 2'd0, p: 2'd3, w: 2'd2, neg: 1'b1, first: 1'b0};
      4'd3:    t = '{k: 2'd1, p: 2'd0, w: 2'd0, neg: 1'b0, first: 1'b1};
      4'd4:    t = '{k: 2'd1, p: 2'd2, w: 2'd2, neg: 1'b0, first: 1'b0};
      4'd5:    t = '{k: 2'd1, p: 2'd3, w: 2'd1, neg: 1'b1, first: 1'b0};
      4'd6:    t = '{k: 2'd2, p: 2'd0, w: 2'd1, neg: 1'b0, first: 1'b1};
      4'd7:    t = '{k: 2'd2, p: 2'd1, w: 2'd2, neg: 1'b1, first: 1'b0};
      4'd8:    t = '{k: 2'd2, p: 2'd3, w: 2'd0, neg: 1'b0, first: 1'b0};
      4'd9:    t = '{k: 2'd3, p: 2'd0, w: 2'd2, neg: 1'b0, first: 1'b1};
      4'd10:   t = '{k: 2'd3, p: 2'd1, w: 2'd1, neg: 1'b0, first: 1'b0};
      4'd11:   t = '{k: 2'd3, p: 2'd2, w: 2'd0, neg: 1'b1, first: 1'b0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(logic signed [DER_W:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qri_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module qri_mul (
  input  wire logic                                 clk,
  input  wire logic signed [qri_pkg::MUL_W-1:0]     mul_a,
  input  wire logic signed [qri_pkg::MUL_W-1:0]     mul_b,
  output logic signed      [2*qri_pkg::MUL_W-1:0]   prod_r
);
  import qri_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_rate_integrator.sv =====
// Top level: Heun step of quaternion kinematics on one shared multiplier.
// The sequencer issues 40 multiplies on the shared 33x33 multiplier, folds the
// last product, then publishes the result. A new item is accepted only when idle,
// after the previous result is published; publishing waits while the result side stalls.
// Reset (rst_n low, synchronous): step time to about 5 ms, stored rates to zero,
// no result pending.
`default_nettype none
module quaternion_rate_integrator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [28:0]        cfg_step_time,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_quat_w,
  input  wire logic signed [31:0] in_quat_x,
  input  wire logic signed [31:0] in_quat_y,
  input  wire logic signed [31:0] in_quat_z,
  input  wire logic signed [31:0] in_rate_x,
  input  wire logic signed [31:0] in_rate_y,
  input  wire logic signed [31:0] in_rate_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_new_w,
  output logic signed [31:0]      out_new_x,
  output logic signed [31:0]      out_new_y,
  output logic signed [31:0]      out_new_z
);
  import qri_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_r;
  logic [1:0]              phase_r;
  logic [3:0]              idx_r;
  logic [STEP_W-1:0]       step_time_r;
  acc_ctl_t                acc_ctl_r;

  logic signed [Q_W-1:0]   q_r   [4];
  logic signed [Q_W-1:0]   m_r   [4];
  logic signed [Q_W-1:0]   res_r [4];
  logic signed [Q_W-1:0]   out_r [4];
  logic signed [Q_W-1:0]   wo_r  [3];
  logic signed [Q_W-1:0]   wn_r  [3];
  logic signed [DER_W-1:0] f_r   [4];
  logic signed [DER_W-1:0] l_r   [4];
  logic [STEP_W-1:0]       tmp_r;
  logic                    out_valid_r;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] prod_r;

  term_t                   term_i;
  term_t                   term_a;
  logic [1:0]              ti_k;
  logic [1:0]              ta_k;
  logic signed [DER_W:0]   d_op;
  logic [MUL_W-1:0]        dt_op;
  logic signed [DER_W-1:0] hp;
  logic signed [DER_W-1:0] base;
  logic signed [DER_W-1:0] acc_nxt;
  logic signed [55:0]      ts_sum;
  logic signed [DER_W-1:0] ts;
  logic signed [DER_W-1:0] add_v;
  logic signed [Q_W-1:0]   upd_nxt;
  logic                    in_acc;
  logic                    publish;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign publish   = (state_r == ST_DONE) && !acc_ctl_r.valid
                     && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_new_w = out_r[0];
  assign out_new_x = out_r[1];
  assign out_new_y = out_r[2];
  assign out_new_z = out_r[3];

  // issue side: pick multiplier operands for the current step
  always_comb begin
    term_i = deriv_term(idx_r);
    ti_k   = idx_r[2:1];
    dt_op  = {4'd0, step_time_r};
    if (phase_r == PH_O) begin
      d_op = 41'(f_r[ti_k]) + 41'(l_r[ti_k]);
    end else begin
      d_op = 41'(f_r[ti_k]);
    end
    mul_a = '0;
    mul_b = '0;
    unique case (phase_r) inside
      PH_F: begin
        mul_a = 33'(q_r[term_i.p]);
        mul_b = 33'(wo_r[term_i.w]);
      end
      PH_L: begin
        mul_a = 33'(m_r[term_i.p]);
        mul_b = 33'(wn_r[term_i.w]);
      end
      PH_M, PH_O: begin
        // low half first, unsigned; high half signed
        if (idx_r[0]) begin
          mul_a = 33'($signed(d_op[DER_W:16]));
        end else begin
          mul_a = {17'd0, d_op[15:0]};
        end
        mul_b = dt_op;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  qri_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // accumulate side: fold the product of the previous step
  always_comb begin
    term_a = deriv_term(acc_ctl_r.idx);
    ta_k   = acc_ctl_r.idx[2:1];
    hp     = 40'($signed(prod_r[63:25]));
    if (term_a.first) begin
      base = '0;
    end else if (acc_ctl_r.phase == PH_F) begin
      base = f_r[term_a.k];
    end else begin
      base = l_r[term_a.k];
    end
    acc_nxt = term_a.neg ? (base - hp) : (base + hp);
    ts_sum  = 56'($signed(prod_r[54:0])) + 56'(tmp_r);
    ts      = 40'(ts_sum >>> 16);
    add_v   = (acc_ctl_r.phase == PH_O) ? (ts >>> 1) : ts;
    upd_nxt = sat32(41'(q_r[ta_k]) + 41'(add_v));
  end

  always_ff @(posedge clk) begin
    if (acc_ctl_r.valid) begin
      case (acc_ctl_r.phase)
        PH_F: f_r[term_a.k] <= acc_nxt;
        PH_L: l_r[term_a.k] <= acc_nxt;
        PH_M: begin
          if (acc_ctl_r.idx[0]) begin
            m_r[ta_k] <= upd_nxt;
          end else begin
            tmp_r <= prod_r[44:16];
          end
        end
        default: begin
          if (acc_ctl_r.idx[0]) begin
            res_r[ta_k] <= upd_nxt;
          end else begin
            tmp_r <= prod_r[44:16];
          end
        end
      endcase
    end
    if (in_acc) begin
      q_r[0]  <= in_quat_w;
      q_r[1]  <= in_quat_x;
      q_r[2]  <= in_quat_y;
      q_r[3]  <= in_quat_z;
      wn_r[0] <= in_rate_x;
      wn_r[1] <= in_rate_y;
      wn_r[2] <= in_rate_z;
    end
    if (publish) begin
      out_r <= res_r;
    end
  end

  // sequencer, configuration and stored rates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_F;
      idx_r       <= '0;
      acc_ctl_r   <= '0;
      step_time_r <= STEP_RESET;
      out_valid_r <= 1'b0;
      wo_r[0]     <= '0;
      wo_r[1]     <= '0;
      wo_r[2]     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_time_r <= cfg_step_time;
      end
      acc_ctl_r <= '{valid: (state_r == ST_RUN), phase: phase_r, idx: idx_r};
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RUN;
            phase_r <= PH_F;
            idx_r   <= '0;
          end
        end
        ST_RUN: begin
          if (((phase_r == PH_F) || (phase_r == PH_L)) && (idx_r == TERM_LAST)) begin
            phase_r <= phase_r + 2'd1;
            idx_r   <= '0;
          end else if ((phase_r == PH_M) && (idx_r == STEP_LAST)) begin
            phase_r <= PH_L;
            idx_r   <= '0;
          end else if ((phase_r == PH_O) && (idx_r == STEP_LAST)) begin
            state_r <= ST_DONE;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        ST_DONE: begin
          // hold the result until the output word slot is free
          if (publish) begin
            wo_r    <= wn_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
